// ----- rtl/sem_pkg.sv -----
// Shared types and constants of the Sobel edge magnitude unit.
`timescale 1ns / 1ps

package sem_pkg;

   // Line store geometry
   localparam int MAX_WIDTH  = 2048;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = 11;
   localparam int SIZE_W     = 12;
   localparam int PIX_W      = 8;

   // Frame size limits and reset values
   localparam logic [SIZE_W-1:0] MAX_WIDTH_SIZE  = SIZE_W'(MAX_WIDTH);
   localparam logic [SIZE_W-1:0] MAX_HEIGHT_SIZE = 12'd2048;
   localparam logic [SIZE_W-1:0] WIDTH_RESET     = 12'd640;
   localparam logic [SIZE_W-1:0] HEIGHT_RESET    = 12'd480;

   // Luma weights in thousandths and the reciprocal of 125 scaled by 2^22
   localparam int LUMA_SUM_W = 18;
   localparam logic [LUMA_SUM_W-1:0] WEIGHT_RED   = 18'd299;
   localparam logic [LUMA_SUM_W-1:0] WEIGHT_GREEN = 18'd587;
   localparam logic [LUMA_SUM_W-1:0] WEIGHT_BLUE  = 18'd114;
   localparam int GRAY_PROD_W = 31;
   localparam logic [GRAY_PROD_W-1:0] RECIP_125   = 31'd33555;
   localparam int RECIP_SHIFT = 22;

   // Gradient and squared-sum widths
   localparam int GRAD_W   = 11;
   localparam int SQ_W     = 20;
   localparam int SUM_SQ_W = 21;
   localparam logic [PIX_W-1:0] MAG_SAT = 8'd255;

   // Configuration register index (paddr bit 2)
   localparam logic CSR_FRAME_WIDTH  = 1'b0;
   localparam logic CSR_FRAME_HEIGHT = 1'b1;

   // Sequencer states
   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_GRAY   = 8'b0000_0010,
      ST_WIN    = 8'b0000_0100,
      ST_GRAD   = 8'b0000_1000,
      ST_SQUARE = 8'b0001_0000,
      ST_SUM    = 8'b0010_0000,
      ST_ROOT   = 8'b0100_0000,
      ST_OUT    = 8'b1000_0000
   } sem_state_type;

   // Status of the square-root unit
   typedef struct packed {
      logic             done;
      logic [PIX_W-1:0] root;
   } sem_root_status_type;

endpackage

// ----- rtl/sem_isqrt.sv -----
// Iterative saturating integer square root, one result bit per cycle.
`timescale 1ns / 1ps

module sem_isqrt (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [sem_pkg::SUM_SQ_W-1:0] value,
   output sem_pkg::sem_root_status_type status
);
   import sem_pkg::*;

   logic [15:0]      value_ff, value_in;
   logic [PIX_W-1:0] root_ff, root_in;
   logic [PIX_W-1:0] bit_ff, bit_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [PIX_W-1:0] trial;
   logic [15:0]      trial_sq;

   // Try the next root bit against the operand
   assign trial    = root_ff | bit_ff;
   assign trial_sq = 16'(trial) * 16'(trial);

   always_comb begin
      value_in = value_ff;
      root_in  = root_ff;
      bit_in   = bit_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         // Saturate at once when the operand reaches 256 squared
         if (value[SUM_SQ_W-1:16] != '0) begin
            root_in = MAG_SAT;
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            value_in = value[15:0];
            root_in  = '0;
            bit_in   = 8'h80;
            busy_in  = 1'b1;
         end
      end else if (busy_ff) begin
         if (trial_sq <= value_ff) begin
            root_in = trial;
         end
         bit_in = bit_ff >> 1;
         if (bit_ff[0]) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      value_ff <= value_in;
      root_ff  <= root_in;
      bit_ff   <= bit_in;
   end

   assign status.done = done_ff;
   assign status.root = root_ff;

endmodule

// ----- rtl/sobel_edge_magnitude_unit.sv -----
// Top level of the Sobel edge magnitude unit: line stores, window, sequencer, CSRs.
`timescale 1ns / 1ps

// Takes RGB pixels in raster order, turns each into gray, keeps the two previous
// gray rows in two 2048-entry line memories and slides a 3x3 window; each interior
// centre pixel yields one item with floor(sqrt(gx^2+gy^2)) saturated at 255, its
// column and row, and a flag on the frame's last interior result. Border pixels
// yield nothing. One pixel is worked on at a time, through states IDLE, GRAY and WIN;
// an interior pixel goes on through GRAD, SQUARE, SUM, ROOT (mostly in the square-root
// unit, which resolves one root bit per cycle unless the magnitude saturates) and OUT,
// which waits for the output register to free. A finished item waits there while the
// next pixel is taken. Frame width and height sit at byte addresses 0 and 4; the user
// must see they are written only while the unit is idle; the unit does not enforce it.

module sobel_edge_magnitude_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [sem_pkg::PIX_W-1:0] req_red,
   input  logic [sem_pkg::PIX_W-1:0] req_green,
   input  logic [sem_pkg::PIX_W-1:0] req_blue,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [sem_pkg::PIX_W-1:0] rsp_edge_magnitude,
   output logic [sem_pkg::COL_W-1:0] rsp_centre_column,
   output logic [sem_pkg::ROW_W-1:0] rsp_centre_row,
   output logic                      rsp_frame_done,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [2:0]                csr_paddr,
   input  logic [31:0]               csr_pwdata,
   output logic [31:0]               csr_prdata,
   output logic                      csr_pready
);
   import sem_pkg::*;

   // Configuration registers
   logic [SIZE_W-1:0] frame_width_ff, frame_width_in;
   logic [SIZE_W-1:0] frame_height_ff, frame_height_in;
   logic              csr_write;

   // Sequencer and counters
   sem_state_type     state_ff, state_in;
   logic [COL_W-1:0]  column_ff, column_in;
   logic [ROW_W-1:0]  row_ff, row_in;

   // Datapath registers
   logic [LUMA_SUM_W-1:0] luma_ff, luma_in;
   logic [GRAY_PROD_W-1:0] prod_ff, prod_in;
   logic [PIX_W-1:0]  win_ff [0:2][0:2];
   logic [PIX_W-1:0]  win_in [0:2][0:2];
   logic [COL_W-1:0]  cen_col_ff, cen_col_in;
   logic [ROW_W-1:0]  cen_row_ff, cen_row_in;
   logic              last_ff, last_in;
   logic signed [GRAD_W-1:0] gx_ff, gx_in, gy_ff, gy_in;
   logic [SQ_W-1:0]   gx2_ff, gx2_in, gy2_ff, gy2_in;

   // Output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0]  rsp_mag_ff, rsp_mag_in;
   logic [COL_W-1:0]  rsp_col_ff, rsp_col_in;
   logic [ROW_W-1:0]  rsp_row_ff, rsp_row_in;
   logic              rsp_done_ff, rsp_done_in;

   // Line memories: row r-1 and row r-2
   logic [PIX_W-1:0]  line_mid_ff [0:MAX_WIDTH-1];
   logic [PIX_W-1:0]  line_top_ff [0:MAX_WIDTH-1];
   logic [PIX_W-1:0]  mid_rd_ff, top_rd_ff;

   // Combinational helpers
   logic              req_accept;
   logic              rsp_accept;
   logic [SIZE_W-1:0] width_eff, height_eff;
   logic              last_col, last_row;
   logic [PIX_W-1:0]  gray;
   logic [9:0]        sx_pos, sx_neg, sy_pos, sy_neg;
   logic signed [2*GRAD_W-1:0] gx_sq, gy_sq;
   logic [SUM_SQ_W-1:0] sum_sq;
   logic              root_start;
   sem_root_status_type root_status;

   // Handshakes
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid_ff && !rsp_stall;

   // Register file
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      if (csr_write) begin
         unique case (csr_paddr[2])
            CSR_FRAME_WIDTH:  frame_width_in  = csr_pwdata[SIZE_W-1:0];
            CSR_FRAME_HEIGHT: frame_height_in = csr_pwdata[SIZE_W-1:0];
            default:          frame_width_in  = frame_width_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         CSR_FRAME_WIDTH:  csr_prdata = {20'b0, frame_width_ff};
         CSR_FRAME_HEIGHT: csr_prdata = {20'b0, frame_height_ff};
         default:          csr_prdata = '0;
      endcase
   end

   // Clamp frame size to 1..max
   always_comb begin
      if (frame_width_ff == '0) begin
         width_eff = 12'd1;
      end else if (frame_width_ff > MAX_WIDTH_SIZE) begin
         width_eff = MAX_WIDTH_SIZE;
      end else begin
         width_eff = frame_width_ff;
      end
      if (frame_height_ff == '0) begin
         height_eff = 12'd1;
      end else if (frame_height_ff > MAX_HEIGHT_SIZE) begin
         height_eff = MAX_HEIGHT_SIZE;
      end else begin
         height_eff = frame_height_ff;
      end
   end

   assign last_col = ({1'b0, column_ff} + 12'd1) >= width_eff;
   assign last_row = ({1'b0, row_ff} + 12'd1) >= height_eff;

   // Gray = floor(floor(luma/8) / 125) via reciprocal
   assign gray = prod_ff[RECIP_SHIFT +: PIX_W];

   // Sobel sums on the updated window
   assign sx_pos = 10'(win_ff[0][2]) + {1'b0, win_ff[1][2], 1'b0} + 10'(win_ff[2][2]);
   assign sx_neg = 10'(win_ff[0][0]) + {1'b0, win_ff[1][0], 1'b0} + 10'(win_ff[2][0]);
   assign sy_pos = 10'(win_ff[2][0]) + {1'b0, win_ff[2][1], 1'b0} + 10'(win_ff[2][2]);
   assign sy_neg = 10'(win_ff[0][0]) + {1'b0, win_ff[0][1], 1'b0} + 10'(win_ff[0][2]);

   assign gx_sq  = gx_ff * gx_ff;
   assign gy_sq  = gy_ff * gy_ff;
   assign sum_sq = {1'b0, gx2_ff} + {1'b0, gy2_ff};
   assign root_start = (state_ff == ST_SUM);

   sem_isqrt u_isqrt (
      .clock  (clock),
      .reset  (reset),
      .start  (root_start),
      .value  (sum_sq),
      .status (root_status)
   );

   // Sequencer and datapath next values
   always_comb begin
      state_in     = state_ff;
      column_in    = column_ff;
      row_in       = row_ff;
      luma_in      = luma_ff;
      prod_in      = prod_ff;
      win_in       = win_ff;
      cen_col_in   = cen_col_ff;
      cen_row_in   = cen_row_ff;
      last_in      = last_ff;
      gx_in        = gx_ff;
      gy_in        = gy_ff;
      gx2_in       = gx2_ff;
      gy2_in       = gy2_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_accept;
      rsp_mag_in   = rsp_mag_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_done_in  = rsp_done_ff;

      unique case (state_ff)
         ST_IDLE: begin
            // Take a pixel and form its weighted luma sum
            if (req_accept) begin
               luma_in = 18'(req_red) * WEIGHT_RED + 18'(req_green) * WEIGHT_GREEN
                       + 18'(req_blue) * WEIGHT_BLUE;
               state_in = ST_GRAY;
            end
         end
         ST_GRAY: begin
            prod_in  = 31'(luma_ff[LUMA_SUM_W-1:3]) * RECIP_125;
            state_in = ST_WIN;
         end
         ST_WIN: begin
            // Shift the window and advance the raster position
            for (int i = 0; i < 3; i++) begin
               win_in[i][0] = win_ff[i][1];
               win_in[i][1] = win_ff[i][2];
            end
            win_in[0][2] = top_rd_ff;
            win_in[1][2] = mid_rd_ff;
            win_in[2][2] = gray;
            cen_col_in   = column_ff - 11'd1;
            cen_row_in   = row_ff - 11'd1;
            last_in      = last_col && last_row;
            if (last_col) begin
               column_in = '0;
               row_in    = last_row ? '0 : row_ff + 11'd1;
            end else begin
               column_in = column_ff + 11'd1;
            end
            if (column_ff >= 11'd2 && row_ff >= 11'd2) begin
               state_in = ST_GRAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_GRAD: begin
            gx_in    = $signed({1'b0, sx_pos}) - $signed({1'b0, sx_neg});
            gy_in    = $signed({1'b0, sy_pos}) - $signed({1'b0, sy_neg});
            state_in = ST_SQUARE;
         end
         ST_SQUARE: begin
            gx2_in   = gx_sq[SQ_W-1:0];
            gy2_in   = gy_sq[SQ_W-1:0];
            state_in = ST_SUM;
         end
         ST_SUM: begin
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            if (root_status.done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // Load the output register once it is free
            if (!rsp_valid_ff || rsp_accept) begin
               rsp_valid_in = 1'b1;
               rsp_mag_in   = root_status.root;
               rsp_col_in   = cen_col_ff;
               rsp_row_in   = cen_row_ff;
               rsp_done_in  = last_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         column_ff       <= '0;
         row_ff          <= '0;
         rsp_valid_ff    <= 1'b0;
         frame_width_ff  <= WIDTH_RESET;
         frame_height_ff <= HEIGHT_RESET;
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               win_ff[i][j] <= '0;
            end
         end
      end else begin
         state_ff        <= state_in;
         column_ff       <= column_in;
         row_ff          <= row_in;
         rsp_valid_ff    <= rsp_valid_in;
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         win_ff          <= win_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      luma_ff     <= luma_in;
      prod_ff     <= prod_in;
      cen_col_ff  <= cen_col_in;
      cen_row_ff  <= cen_row_in;
      last_ff     <= last_in;
      gx_ff       <= gx_in;
      gy_ff       <= gy_in;
      gx2_ff      <= gx2_in;
      gy2_ff      <= gy2_in;
      rsp_mag_ff  <= rsp_mag_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_done_ff <= rsp_done_in;
   end

   // Read both line memories at the pixel's column
   always_ff @(posedge clock) begin
      if (req_accept) begin
         mid_rd_ff <= line_mid_ff[column_ff];
         top_rd_ff <= line_top_ff[column_ff];
      end
   end

   // Write back: new gray into row r-1, old row r-1 into row r-2
   always_ff @(posedge clock) begin
      if (state_ff == ST_WIN) begin
         line_mid_ff[column_ff] <= gray;
         line_top_ff[column_ff] <= mid_rd_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_edge_magnitude = rsp_mag_ff;
   assign rsp_centre_column  = rsp_col_ff;
   assign rsp_centre_row     = rsp_row_ff;
   assign rsp_frame_done     = rsp_done_ff;

endmodule

// ----- verif/tb_top.sv -----
// Testbench of the Sobel edge magnitude unit: pixel driver, result checker and CSR setup.
`timescale 1ns / 1ps

module tb_top;
   import sem_pkg::*;

   localparam int STORE_DEPTH        = 2 * MAX_WIDTH;
   localparam int MAX_GAP            = 14;
   localparam int SETTLE_CYCLES      = 48;
   localparam int DRAIN_LIMIT        = 200000;
   localparam int HOLD_CYCLES        = 600;
   localparam int RANDOM_PIXELS      = 850;
   localparam int unsigned TIMEOUT_NS = 20_000_000;

   typedef enum int {GAP_NONE, GAP_SPARSE, GAP_FULL} gap_mode_type;
   typedef enum int {PAT_NOISE, PAT_FLAT, PAT_RAMP, PAT_BINARY, PAT_SMOOTH} pattern_type;

   typedef struct packed {
      logic [PIX_W-1:0] magnitude;
      logic [COL_W-1:0] column;
      logic [ROW_W-1:0] row;
      logic             done;
   } edge_result_type;

   // Predict edge results from accepted pixels and check the block's items against them
   class edge_scoreboard;
      logic [PIX_W-1:0]  gray_line [STORE_DEPTH];
      logic [PIX_W-1:0]  win [3][3];
      int unsigned       col_cnt;
      int unsigned       row_cnt;
      logic [SIZE_W-1:0] frame_width;
      logic [SIZE_W-1:0] frame_height;
      edge_result_type   expected_edges [$];
      int                errors;

      function new();
         foreach (gray_line[i]) gray_line[i] = '0;
         foreach (win[i, j]) win[i][j] = '0;
         col_cnt      = 0;
         row_cnt      = 0;
         frame_width  = WIDTH_RESET;
         frame_height = HEIGHT_RESET;
         errors       = 0;
      endfunction

      function int unsigned clamp_size(logic [SIZE_W-1:0] v, int unsigned hi);
         if (v == 0) return 1;
         if (v > hi) return hi;
         return v;
      endfunction

      function logic [PIX_W-1:0] edge_root(int unsigned s);
         int unsigned m;
         m = 0;
         if (s >= 65536) return MAG_SAT;
         while (m < 255 && (m + 1) * (m + 1) <= s) m++;
         return m[PIX_W-1:0];
      endfunction

      // Count pixels until the raster counters come back to the frame start
      function int unsigned pixels_to_frame_end();
         int unsigned w, h, c, row, n;
         w   = clamp_size(frame_width, MAX_WIDTH);
         h   = clamp_size(frame_height, 2048);
         c   = col_cnt;
         row = row_cnt;
         n   = 0;
         do begin
            n++;
            if (c + 1 >= w) begin
               c   = 0;
               row = (row + 1 >= h) ? 0 : row + 1;
            end else begin
               c++;
            end
         end while (!(c == 0 && row == 0));
         return n;
      endfunction

      function void note_pixel(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g, logic [PIX_W-1:0] b);
         int unsigned  gray, w, h, c, row, sq;
         logic [PIX_W-1:0] top, mid;
         int           gx, gy;
         edge_result_type want;
         gray = (299 * int'(r) + 587 * int'(g) + 114 * int'(b)) / 1000;
         w    = clamp_size(frame_width, MAX_WIDTH);
         h    = clamp_size(frame_height, 2048);
         c    = col_cnt % MAX_WIDTH;
         row  = row_cnt;

         // Shift the line stores down one row at this column
         top = gray_line[MAX_WIDTH + c];
         mid = gray_line[c];
         gray_line[MAX_WIDTH + c] = mid;
         gray_line[c]             = gray[PIX_W-1:0];

         // Slide the window one column left and load the new column
         for (int i = 0; i < 3; i++) begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
         end
         win[0][2] = top;
         win[1][2] = mid;
         win[2][2] = gray[PIX_W-1:0];

         if (c >= 2 && row >= 2) begin
            gx = (int'(win[0][2]) + 2 * int'(win[1][2]) + int'(win[2][2]))
               - (int'(win[0][0]) + 2 * int'(win[1][0]) + int'(win[2][0]));
            gy = (int'(win[2][0]) + 2 * int'(win[2][1]) + int'(win[2][2]))
               - (int'(win[0][0]) + 2 * int'(win[0][1]) + int'(win[0][2]));
            sq = gx * gx + gy * gy;
            want.magnitude = edge_root(sq);
            want.column    = COL_W'(c - 1);
            want.row       = ROW_W'(row - 1);
            want.done      = (c + 1 >= w && row + 1 >= h);
            expected_edges.push_back(want);
         end

         // Advance the raster position
         if (c + 1 >= w) begin
            col_cnt = 0;
            row_cnt = (row + 1 >= h) ? 0 : row + 1;
         end else begin
            col_cnt = c + 1;
         end
      endfunction

      function void compare_field(string name, int unsigned want_v, logic [31:0] got_v,
                                  edge_result_type want);
         if (got_v !== want_v) begin
            $display("%0t: %s mismatch at col %0d row %0d: expected %0d, actual %0d",
                     $time, name, want.column, want.row, want_v, got_v);
            errors++;
         end
      endfunction

      function void check_edge(logic [PIX_W-1:0] mag, logic [COL_W-1:0] col,
                               logic [ROW_W-1:0] row, logic done);
         edge_result_type want;
         if (expected_edges.size() == 0) begin
            $display("%0t: unexpected item: expected none, actual col %0d row %0d magnitude %0d",
                     $time, col, row, mag);
            errors++;
            return;
         end
         want = expected_edges.pop_front();
         compare_field("edge_magnitude", want.magnitude, 32'(mag), want);
         compare_field("centre_column", want.column, 32'(col), want);
         compare_field("centre_row", want.row, 32'(row), want);
         compare_field("frame_done", want.done, 32'(done), want);
      endfunction

      function void check_leftover();
         if (expected_edges.size() != 0) begin
            $display("%0t: %0d expected items never arrived: expected col %0d row %0d, actual none",
                     $time, expected_edges.size(), expected_edges[0].column,
                     expected_edges[0].row);
            errors += expected_edges.size();
         end
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [PIX_W-1:0]  req_red;
   logic [PIX_W-1:0]  req_green;
   logic [PIX_W-1:0]  req_blue;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [PIX_W-1:0]  rsp_edge_magnitude;
   logic [COL_W-1:0]  rsp_centre_column;
   logic [ROW_W-1:0]  rsp_centre_row;
   logic              rsp_frame_done;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [2:0]        csr_paddr;
   logic [31:0]       csr_pwdata;
   logic [31:0]       csr_prdata;
   logic              csr_pready;

   edge_scoreboard    sb;
   gap_mode_type      send_mode;
   gap_mode_type      recv_mode;
   int unsigned       pixels_sent;

   sobel_edge_magnitude_unit DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_red            (req_red),
      .req_green          (req_green),
      .req_blue           (req_blue),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_edge_magnitude (rsp_edge_magnitude),
      .rsp_centre_column  (rsp_centre_column),
      .rsp_centre_row     (rsp_centre_row),
      .rsp_frame_done     (rsp_frame_done),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   // Generate the clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int draw_gap(gap_mode_type mode);
      case (mode)
         GAP_NONE:   return 0;
         GAP_SPARSE: return ($urandom_range(0, 7) == 0) ? $urandom_range(0, MAX_GAP) : 0;
         default:    return $urandom_range(0, MAX_GAP);
      endcase
   endfunction

   // Watch both channels at the rising edge
   always @(posedge clock) begin
      if (!reset && req_valid && req_stall === 1'b0)
         sb.note_pixel(req_red, req_green, req_blue);
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0)
         sb.check_edge(rsp_edge_magnitude, rsp_centre_column, rsp_centre_row, rsp_frame_done);
   end

   // Drain results with random stalls and an occasional long hold-off
   initial begin
      int          gap;
      int unsigned taken;
      taken     = 0;
      rsp_stall = 1'b0;
      forever begin
         gap = draw_gap(recv_mode);
         if (gap > 0) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
            repeat (gap - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (rsp_valid !== 1'b1) @(posedge clock);
         taken++;
         // Hold off long enough for the block to fill and stall its input
         if (taken % 400 == 50) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end
      end
   end

   // Offer one pixel after a random gap and hold it until accepted
   task automatic send_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                             input logic [PIX_W-1:0] b);
      int gap;
      gap = draw_gap(send_mode);
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_red   <= r;
      req_green <= g;
      req_blue  <= b;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      pixels_sent++;
   endtask

   task automatic release_input();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic feed_pixels(input int unsigned n, input pattern_type pat);
      logic [PIX_W-1:0] base_r, base_g, base_b, r, g, b;
      int unsigned      step;
      logic             bit_v;
      base_r = PIX_W'($urandom);
      base_g = PIX_W'($urandom);
      base_b = PIX_W'($urandom);
      step   = $urandom_range(1, 9);
      for (int unsigned i = 0; i < n; i++) begin
         case (pat)
            PAT_NOISE: begin
               r = PIX_W'($urandom);
               g = PIX_W'($urandom);
               b = PIX_W'($urandom);
            end
            PAT_FLAT: begin
               r = base_r;
               g = base_g;
               b = base_b;
            end
            PAT_RAMP: begin
               r = PIX_W'(base_r + i * step);
               g = PIX_W'(base_g + i * step);
               b = PIX_W'(base_b + i * step);
            end
            PAT_BINARY: begin
               bit_v = 1'($urandom_range(0, 1));
               r = {PIX_W{bit_v}};
               g = r;
               b = r;
            end
            default: begin
               r = PIX_W'(base_r + $urandom_range(0, 5));
               g = PIX_W'(base_g + $urandom_range(0, 5));
               b = PIX_W'(base_b + $urandom_range(0, 5));
            end
         endcase
         send_pixel(r, g, b);
      end
      release_input();
   endtask

   // Wait for every expected item, then let pixels without results drain
   task automatic wait_idle();
      int unsigned waited;
      waited = 0;
      while (sb.expected_edges.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic idx, input logic [31:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (csr_pready !== 1'b1) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (idx == CSR_FRAME_WIDTH) sb.frame_width = value[SIZE_W-1:0];
      else sb.frame_height = value[SIZE_W-1:0];
   endtask

   task automatic csr_check(input logic idx, input logic [SIZE_W-1:0] want);
      logic [SIZE_W-1:0] got;
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (csr_pready !== 1'b1) @(posedge clock);
      got = csr_prdata[SIZE_W-1:0];
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (got !== want) begin
         $display("%0t: register %0d read: expected %0d, actual %0d", $time, idx, want, got);
         sb.errors++;
      end
   endtask

   task automatic configure(input int unsigned w, input int unsigned h);
      wait_idle();
      csr_write(CSR_FRAME_WIDTH, 32'(w));
      csr_write(CSR_FRAME_HEIGHT, 32'(h));
      csr_check(CSR_FRAME_WIDTH, SIZE_W'(w));
      csr_check(CSR_FRAME_HEIGHT, SIZE_W'(h));
   endtask

   task automatic run_frame(input int unsigned w, input int unsigned h, input pattern_type pat);
      configure(w, h);
      feed_pixels(sb.pixels_to_frame_end(), pat);
   endtask

   // Resize width, height or both mid-frame; the width never grows, so only written columns are read
   task automatic mid_frame_change(input pattern_type pat);
      int unsigned w0, h0, k, choice;
      w0 = $urandom_range(4, 10);
      h0 = $urandom_range(4, 8);
      configure(w0, h0);
      k = 2 * w0 + $urandom_range(0, (h0 - 2) * w0 - 1);
      feed_pixels(k, pat);
      wait_idle();
      choice = $urandom_range(0, 2);
      if (choice != 1) csr_write(CSR_FRAME_WIDTH, 32'($urandom_range(0, w0)));
      if (choice != 0) csr_write(CSR_FRAME_HEIGHT, 32'($urandom_range(0, h0 + 3)));
      feed_pixels(sb.pixels_to_frame_end(), pat);
   endtask

   // Start a frame at a large size, then shrink it early so only written columns are read
   task automatic large_frame_start(input int unsigned w, input int unsigned h,
                                    input pattern_type pat);
      int unsigned k;
      configure(w, h);
      k = $urandom_range(8, 40);
      feed_pixels(k, pat);
      wait_idle();
      csr_write(CSR_FRAME_WIDTH, 32'($urandom_range(3, 8)));
      csr_write(CSR_FRAME_HEIGHT, 32'd3);
      feed_pixels(sb.pixels_to_frame_end(), pat);
   endtask

   initial begin
      int unsigned random_start, w, h;
      pattern_type pat;
      sb          = new();
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_red     = '0;
      req_green   = '0;
      req_blue    = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      pixels_sent = 0;
      send_mode   = GAP_FULL;
      recv_mode   = GAP_FULL;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      csr_check(CSR_FRAME_WIDTH, WIDTH_RESET);
      csr_check(CSR_FRAME_HEIGHT, HEIGHT_RESET);

      // Smallest frame with an interior: one result from field extremes
      configure(3, 3);
      send_pixel(8'd0, 8'd0, 8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd255, 8'd0, 8'd0);
      send_pixel(8'd0, 8'd255, 8'd0);
      send_pixel(8'd0, 8'd0, 8'd255);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd0, 8'd0, 8'd0);
      send_pixel(8'd128, 8'd64, 8'd32);
      send_pixel(8'd1, 8'd2, 8'd3);
      release_input();

      // Zero size acts as one pixel, tiny frames give nothing
      configure(0, 0);
      send_pixel(8'd255, 8'd255, 8'd255);
      release_input();
      configure(2, 2);
      send_pixel(8'd255, 8'd0, 8'd255);
      send_pixel(8'd0, 8'd255, 8'd0);
      send_pixel(8'd170, 8'd85, 8'd170);
      send_pixel(8'd85, 8'd170, 8'd85);
      release_input();

      // Shrink the width past the current column, then the height past the current row
      configure(3, 5);
      feed_pixels(11, PAT_BINARY);
      wait_idle();
      csr_write(CSR_FRAME_WIDTH, 32'd2);
      feed_pixels(1, PAT_NOISE);
      wait_idle();
      csr_write(CSR_FRAME_HEIGHT, 32'd3);
      feed_pixels(sb.pixels_to_frame_end(), PAT_NOISE);

      // Random frames, mostly small
      random_start = pixels_sent;
      while (pixels_sent - random_start < RANDOM_PIXELS) begin
         send_mode = gap_mode_type'($urandom_range(0, 2));
         recv_mode = gap_mode_type'($urandom_range(0, 2));
         pat       = pattern_type'($urandom_range(0, 4));
         case ($urandom_range(0, 11))
            0: begin
               w = $urandom_range(0, 2);
               h = $urandom_range(0, 6);
               if ($urandom_range(0, 1)) run_frame(w, h, pat);
               else run_frame(h, w, pat);
            end
            1: mid_frame_change(pat);
            2: run_frame($urandom_range(13, 64), $urandom_range(3, 5), pat);
            default: run_frame($urandom_range(3, 12), $urandom_range(3, 8), pat);
         endcase
      end

      // Largest sizes and oversized register values, cut short within the first row
      send_mode = GAP_SPARSE;
      recv_mode = GAP_SPARSE;
      large_frame_start(4095, 4095, PAT_SMOOTH);
      large_frame_start(2048, 2048, PAT_RAMP);

      wait_idle();
      sb.check_leftover();
      if (sb.errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Stop a hung run
   initial begin
      #(TIMEOUT_NS);
      $display("*** FAILED ***");
      $finish;
   end

endmodule
